@@ rtl/nls_pkg.sv @@
// ----------------------------------------------------------------------------
// nls_pkg: shared types and constants for the numeric literal scanner
// Character codes, scanner phase and status codes, payload structs and
// character class helpers.
// ----------------------------------------------------------------------------
package nls_pkg;

  // Default saturation limit for the literal length
  localparam int unsigned MaxLenDefault = 255;

  // Character codes
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharLowE  = 8'h65;
  localparam logic [7:0] CharUpE   = 8'h45;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;

  // Scanner phases
  localparam logic [2:0] PhIdle     = 3'd0;
  localparam logic [2:0] PhDigits   = 3'd1;
  localparam logic [2:0] PhDot      = 3'd2;
  localparam logic [2:0] PhExpSign  = 3'd3;
  localparam logic [2:0] PhExpDigit = 3'd4;

  // Result status codes
  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StSecondDot  = 3'd1;
  localparam logic [2:0] StDotAfterEx = 3'd2;
  localparam logic [2:0] StNoDigitDot = 3'd3;
  localparam logic [2:0] StSecondExp  = 3'd4;
  localparam logic [2:0] StNoDigitExp = 3'd5;
  localparam logic [2:0] StLetter     = 3'd6;

  // Held-back character counts
  localparam logic [1:0] HeldNone  = 2'd0;
  localparam logic [1:0] HeldOne   = 2'd1;
  localparam logic [1:0] HeldRange = 2'd2;

  // Token kinds
  localparam logic KindInt   = 1'b0;
  localparam logic KindFloat = 1'b1;

  typedef struct packed {
    logic [7:0] ch;
    logic       begin_req;
    logic       at_end;
  } char_t;

  typedef struct packed {
    logic       token_kind;
    logic [7:0] literal_length;
    logic [2:0] status;
    logic [1:0] held_back;
  } token_t;

  function automatic logic dec_numeral(input logic [7:0] c);
    dec_numeral = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

@@ rtl/nls_if.sv @@
// ----------------------------------------------------------------------------
// nls_if: channel interfaces of the numeric literal scanner
// Character input channel and token result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nls_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       begin_req;
  logic       at_end;

  modport source (output valid, output ch, output begin_req, output at_end, input ready);
  modport sink   (input valid, input ch, input begin_req, input at_end, output ready);
endinterface

interface nls_tok_if;
  logic       valid;
  logic       ready;
  logic       token_kind;
  logic [7:0] literal_length;
  logic [2:0] status;
  logic [1:0] held_back;

  modport source (output valid, output token_kind, output literal_length,
                  output status, output held_back, input ready);
  modport sink   (input valid, input token_kind, input literal_length,
                  input status, input held_back, output ready);
endinterface

@@ rtl/numeric_literal_scanner.sv @@
// A character is held in the input register; its token, if any, is then registered in the token register.
// Throughput: one character per cycle; a waiting token stalls input only when
// the next character also ends a literal and the token register is still full.
// Reset (rst_ni low, asynchronous): scanner idle, flags and length cleared, both
// registers empty.
// ----------------------------------------------------------------------------
// numeric_literal_scanner: streaming lexer for one numeric literal
// Input register, scanner core and token register in a single-pass pipeline.
// ----------------------------------------------------------------------------
module numeric_literal_scanner #(
  parameter int unsigned MaxLen = nls_pkg::MaxLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nls_char_if.sink   char_i,
  nls_tok_if.source  tok_o
);

  nls_pkg::char_t  char_in;
  nls_pkg::char_t  char_q;
  nls_pkg::token_t token_d;
  nls_pkg::token_t token_q;
  logic            in_valid;
  logic            res_valid;
  logic            out_free;
  logic            advance;

  assign char_in.ch        = char_i.ch;
  assign char_in.begin_req = char_i.begin_req;
  assign char_in.at_end    = char_i.at_end;

  // Held character moves on unless it makes a token with nowhere to go
  assign advance = in_valid && (!res_valid || out_free);

  nls_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (char_i.valid),
    .ready_o (char_i.ready),
    .char_i  (char_in),
    .valid_o (in_valid),
    .take_i  (advance),
    .char_o  (char_q)
  );

  nls_core #(
    .MaxLen (MaxLen)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_q),
    .advance_i   (advance),
    .res_valid_o (res_valid),
    .token_o     (token_d)
  );

  nls_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_valid),
    .token_i (token_d),
    .free_o  (out_free),
    .valid_o (tok_o.valid),
    .ready_i (tok_o.ready),
    .token_o (token_q)
  );

  assign tok_o.token_kind     = token_q.token_kind;
  assign tok_o.literal_length = token_q.literal_length;
  assign tok_o.status         = token_q.status;
  assign tok_o.held_back      = token_q.held_back;

endmodule

@@ rtl/nls_in_stage.sv @@
// ----------------------------------------------------------------------------
// nls_in_stage: character input register
// Captures one character transaction per cycle; frees when the core takes it.
// ----------------------------------------------------------------------------
module nls_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  nls_pkg::char_t  char_i,
  output logic            valid_o,
  input  logic            take_i,
  output nls_pkg::char_t  char_o
);

  logic           valid_q;
  nls_pkg::char_t char_q;

  // Free when empty or when the held character moves on this cycle
  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      char_q <= char_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;

endmodule

@@ rtl/nls_core.sv @@
// ----------------------------------------------------------------------------
// nls_core: scanner state and next-state logic
// Holds phase, point/exponent flags and the saturating length; decides per
// character whether the literal ends and with what token.
// ----------------------------------------------------------------------------
module nls_core #(
  parameter int unsigned MaxLen = nls_pkg::MaxLenDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nls_pkg::char_t  char_i,
  input  logic            advance_i,
  output logic            res_valid_o,
  output nls_pkg::token_t token_o
);

  localparam logic [7:0] LenLimit = (MaxLen > 255) ? 8'd255 : 8'(MaxLen);

  logic [2:0] phase_q, phase_d;
  logic       point_q, point_d;
  logic       exp_q, exp_d;
  logic [7:0] cnt_q, cnt_d;

  logic       clear;
  logic [1:0] inc;
  logic       res;
  logic [2:0] st;
  logic [1:0] held;
  logic [7:0] cnt_base;
  logic [8:0] cnt_sum;
  logic       dig;
  logic       ltr;

  assign dig = nls_pkg::dec_numeral(char_i.ch);
  assign ltr = nls_pkg::is_letter(char_i.ch);

  // Next state and result decision
  always_comb begin
    phase_d = phase_q;
    point_d = point_q;
    exp_d   = exp_q;
    clear   = 1'b0;
    inc     = 2'd0;
    res     = 1'b0;
    st      = nls_pkg::StOk;
    held    = nls_pkg::HeldNone;
    if (char_i.at_end) begin
      case (phase_q)
        nls_pkg::PhDigits: begin
          res = 1'b1;
        end
        nls_pkg::PhDot: begin
          res = 1'b1;
          if (point_q) begin
            st   = nls_pkg::StSecondDot;
            held = nls_pkg::HeldOne;
          end else if (exp_q) begin
            st   = nls_pkg::StDotAfterEx;
            held = nls_pkg::HeldOne;
          end else begin
            point_d = 1'b1;
            inc     = 2'd1;
            st      = nls_pkg::StNoDigitDot;
          end
        end
        nls_pkg::PhExpSign, nls_pkg::PhExpDigit: begin
          res = 1'b1;
          st  = nls_pkg::StNoDigitExp;
        end
        default: begin
          phase_d = nls_pkg::PhIdle;
        end
      endcase
    end else if (char_i.begin_req) begin
      point_d = 1'b0;
      exp_d   = 1'b0;
      clear   = 1'b1;
      if (dig) begin
        inc     = 2'd1;
        phase_d = nls_pkg::PhDigits;
      end else begin
        phase_d = nls_pkg::PhIdle;
      end
    end else begin
      case (phase_q)
        nls_pkg::PhDigits: begin
          if (dig) begin
            inc = 2'd1;
          end else if (char_i.ch == nls_pkg::CharDot) begin
            phase_d = nls_pkg::PhDot;
          end else if (char_i.ch == nls_pkg::CharLowE || char_i.ch == nls_pkg::CharUpE) begin
            if (exp_q) begin
              res  = 1'b1;
              st   = nls_pkg::StSecondExp;
              held = nls_pkg::HeldOne;
            end else begin
              exp_d   = 1'b1;
              inc     = 2'd1;
              phase_d = nls_pkg::PhExpSign;
            end
          end else begin
            res  = 1'b1;
            st   = ltr ? nls_pkg::StLetter : nls_pkg::StOk;
            held = nls_pkg::HeldOne;
          end
        end
        nls_pkg::PhDot: begin
          if (char_i.ch == nls_pkg::CharDot) begin
            // Range operator: both dots go back to the source
            res  = 1'b1;
            held = nls_pkg::HeldRange;
          end else if (point_q) begin
            res  = 1'b1;
            st   = nls_pkg::StSecondDot;
            held = nls_pkg::HeldRange;
          end else if (exp_q) begin
            res  = 1'b1;
            st   = nls_pkg::StDotAfterEx;
            held = nls_pkg::HeldRange;
          end else begin
            point_d = 1'b1;
            if (dig) begin
              inc     = 2'd2;
              phase_d = nls_pkg::PhDigits;
            end else begin
              inc  = 2'd1;
              res  = 1'b1;
              st   = nls_pkg::StNoDigitDot;
              held = nls_pkg::HeldOne;
            end
          end
        end
        nls_pkg::PhExpSign: begin
          if (char_i.ch == nls_pkg::CharPlus || char_i.ch == nls_pkg::CharMinus) begin
            inc     = 2'd1;
            phase_d = nls_pkg::PhExpDigit;
          end else if (dig) begin
            inc     = 2'd1;
            phase_d = nls_pkg::PhDigits;
          end else begin
            res  = 1'b1;
            st   = nls_pkg::StNoDigitExp;
            held = nls_pkg::HeldOne;
          end
        end
        nls_pkg::PhExpDigit: begin
          if (dig) begin
            inc     = 2'd1;
            phase_d = nls_pkg::PhDigits;
          end else begin
            res  = 1'b1;
            st   = nls_pkg::StNoDigitExp;
            held = nls_pkg::HeldOne;
          end
        end
        default: begin
          phase_d = nls_pkg::PhIdle;
        end
      endcase
    end
    if (res) begin
      phase_d = nls_pkg::PhIdle;
    end
  end

  // Saturating length update (count never exceeds the limit)
  assign cnt_base = clear ? 8'd0 : cnt_q;
  assign cnt_sum  = {1'b0, cnt_base} + {7'd0, inc};
  assign cnt_d    = (cnt_sum > {1'b0, LenLimit}) ? LenLimit : cnt_sum[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nls_pkg::PhIdle;
      point_q <= 1'b0;
      exp_q   <= 1'b0;
      cnt_q   <= 8'd0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      point_q <= point_d;
      exp_q   <= exp_d;
      cnt_q   <= cnt_d;
    end
  end

  assign res_valid_o            = res;
  assign token_o.token_kind     = (point_d | exp_d) ? nls_pkg::KindFloat : nls_pkg::KindInt;
  assign token_o.literal_length = cnt_d;
  assign token_o.status         = st;
  assign token_o.held_back      = held;

  // A finished literal always returns the scanner to idle
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res |=> phase_q == nls_pkg::PhIdle)
    else $error("scanner not idle after a token");

  // Exponent phases only follow an accepted exponent marker
  a_exp_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == nls_pkg::PhExpSign || phase_q == nls_pkg::PhExpDigit) |-> exp_q)
    else $error("exponent phase without exponent flag");

  // Every reported literal holds at least its first digit
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res |-> cnt_d != 8'd0)
    else $error("token with zero length");

  // A new literal starts with clean flags
  a_begin_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && char_i.begin_req && !char_i.at_end |=> !point_q && !exp_q)
    else $error("flags not cleared on literal start");

endmodule

@@ rtl/nls_out_stage.sv @@
// ----------------------------------------------------------------------------
// nls_out_stage: token result register
// Holds one token transaction until the sink takes it; reloads in the same
// cycle the old one leaves.
// ----------------------------------------------------------------------------
module nls_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  nls_pkg::token_t token_i,
  output logic            free_o,
  output logic            valid_o,
  input  logic            ready_i,
  output nls_pkg::token_t token_o
);

  logic            valid_q;
  nls_pkg::token_t token_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      token_q <= token_i;
    end
  end

  assign valid_o = valid_q;
  assign token_o = token_q;

endmodule
